FILE: design/shsk_pkg.sv
package shsk_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ADDR_W     = $clog2(CAPACITY);

    localparam int DIV3_SHIFT = CNT_W + 1;
    localparam int DIV3_RECIP = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int DIV3_W     = CNT_W + DIV3_SHIFT;

endpackage

FILE: design/shsk_ram.sv
module shsk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/shell_sort_knuth_gaps_top.sv
// Load: one item per cycle while s_ready is high; results appear only after the last item.
// Sort: S_GAPINIT steps the gap through 3h+1 to the first gap, then each element of a pass
// runs S_OUTER, S_HOLD, S_CMP (again per element moved), through the store's one read and one write port.
// Output: after sorting, each result is read in S_ELAT and held in S_EOUT until m_ready takes it.
// aresetn (synchronous, active low) clears the control state; the store is not cleared.
module shell_sort_knuth_gaps_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [shsk_pkg::DATA_W-1:0]  s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [shsk_pkg::DATA_W-1:0]  m_sorted_value,
    output logic                                m_final_res,
    output logic                                m_overflow
);

    import shsk_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_GAPINIT,
        S_OUTER,
        S_HOLD,
        S_CMP,
        S_PLACE,
        S_ELAT,
        S_EOUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          gap_reg, gap_next;
    logic [CNT_W-1:0]          outer_reg, outer_next;
    logic [CNT_W-1:0]          inner_reg, inner_next;
    logic signed [DATA_W-1:0]  held_reg, held_next;
    logic                      drop_reg, drop_next;
    logic signed [DATA_W-1:0]  out_value_reg, out_value_next;
    logic                      out_final_reg, out_final_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  rd_value;

    logic [CNT_W+1:0]          cand;
    logic [CNT_W+5:0]          cand9;
    logic [CNT_W-1:0]          gap_dec;
    logic [DIV3_W-1:0]         div3_prod;
    logic [CNT_W-1:0]          gap_down;
    logic [CNT_W-1:0]          outer_dn;
    logic [CNT_W-1:0]          inner_dn;
    logic [CNT_W-1:0]          inner_dn2;
    logic [CNT_W-1:0]          outer_inc;

    shsk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value  = $signed(ram_rdata);
    assign cand      = ({2'b00, gap_reg} << 1) + {2'b00, gap_reg} + (CNT_W+2)'(1);
    assign cand9     = ({4'h0, cand} << 3) + {4'h0, cand};
    assign gap_dec   = gap_reg - CNT_W'(1);
    assign div3_prod = DIV3_W'(gap_dec) * DIV3_W'(DIV3_RECIP);
    assign gap_down  = div3_prod[DIV3_SHIFT +: CNT_W];
    assign outer_dn  = outer_reg - gap_reg;
    assign inner_dn  = inner_reg - gap_reg;
    assign inner_dn2 = inner_dn - gap_reg;
    assign outer_inc = outer_reg + CNT_W'(1);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        gap_next       = gap_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = s_value;
        ram_raddr      = outer_reg[ADDR_W-1:0];
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last) begin
                        gap_next   = CNT_W'(1);
                        state_next = S_GAPINIT;
                    end
                end
            end
            S_GAPINIT: begin
                if (cand9 <= (CNT_W+6)'(count_reg)) begin
                    gap_next = cand[CNT_W-1:0];
                end else begin
                    outer_next = gap_reg;
                    state_next = S_OUTER;
                end
            end
            S_OUTER: begin
                if (outer_reg < count_reg) begin
                    state_next = S_HOLD;
                end else if (gap_down == '0) begin
                    gap_next   = '0;
                    outer_next = '0;
                    ram_raddr  = '0;
                    state_next = S_ELAT;
                end else begin
                    gap_next   = gap_down;
                    outer_next = gap_down;
                end
            end
            S_HOLD: begin
                held_next  = rd_value;
                inner_next = outer_reg;
                ram_raddr  = outer_dn[ADDR_W-1:0];
                state_next = S_CMP;
            end
            S_CMP: begin
                ram_waddr = inner_reg[ADDR_W-1:0];
                if (held_reg < rd_value) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    inner_next = inner_dn;
                    ram_raddr  = inner_dn2[ADDR_W-1:0];
                    if (inner_dn < gap_reg) begin
                        state_next = S_PLACE;
                    end
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = held_reg;
                    outer_next = outer_inc;
                    state_next = S_OUTER;
                end
            end
            S_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = inner_reg[ADDR_W-1:0];
                ram_wdata  = held_reg;
                outer_next = outer_inc;
                state_next = S_OUTER;
            end
            S_ELAT: begin
                out_value_next = rd_value;
                out_final_next = (outer_inc == count_reg);
                out_valid_next = 1'b1;
                state_next     = S_EOUT;
            end
            S_EOUT: begin
                if (m_ready) begin
                    out_valid_next = 1'b0;
                    if (out_final_reg) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        outer_next = outer_inc;
                        ram_raddr  = outer_inc[ADDR_W-1:0];
                        state_next = S_ELAT;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            gap_reg       <= '0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            held_reg      <= '0;
            drop_reg      <= 1'b0;
            out_final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            gap_reg       <= gap_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            held_reg      <= held_next;
            drop_reg      <= drop_next;
            out_final_reg <= out_final_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg <= out_value_next;
    end

    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = out_valid_reg;
    assign m_sorted_value = out_value_reg;
    assign m_final_res    = out_final_reg;
    assign m_overflow     = drop_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while an item is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("item count beyond capacity");

    a_gap_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUTER || state_reg == S_HOLD || state_reg == S_CMP
         || state_reg == S_PLACE) |-> (gap_reg != '0))
        else $error("zero gap during sort");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_res) |=> (s_ready && count_reg == '0 && !m_overflow))
        else $error("run did not return to load");

    a_out_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (outer_reg < count_reg))
        else $error("output index past set");

endmodule

FILE: tb/shell_sort_knuth_gaps_top_test.sv
`timescale 1ns / 100ps

module shell_sort_knuth_gaps_top_test;
    import shsk_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } load_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     is_final;
        logic                     dropped;
    } sorted_item_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } spread_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     s_last  = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_final_res;
    logic                     m_overflow;

    load_item_t               pending_items[$];
    load_item_t               next_item;
    sorted_item_t             sorted_q[$];
    sorted_item_t             want;

    logic signed [DATA_W-1:0] load_buf[CAPACITY];
    int unsigned              load_count   = 0;
    logic                     load_dropped = 1'b0;

    int unsigned              in_hold  = 0;
    int unsigned              in_calm  = 0;
    int unsigned              out_hold = 0;
    int unsigned              out_calm = 0;
    int unsigned              out_draw;
    int unsigned              errors   = 0;
    int unsigned              random_items;
    int unsigned              set_size;

    shell_sort_knuth_gaps_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_final_res    (m_final_res),
        .m_overflow     (m_overflow)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("shell_sort_knuth_gaps_top regression: fail");
        $finish;
    end

    // Store one element, and on the last one sort by Knuth-gap Shell sort and queue the set.
    task automatic predict_sorted(input logic signed [DATA_W-1:0] v, input logic is_last);
        int unsigned              h;
        int unsigned              stride;
        int unsigned              i;
        int unsigned              j;
        logic signed [DATA_W-1:0] held;
        sorted_item_t             res;
        if (load_count < CAPACITY) begin
            load_buf[load_count] = v;
            load_count++;
        end else begin
            load_dropped = 1'b1;
        end
        if (!is_last) return;
        stride = 1;
        for (h = 1; h <= load_count / 9; h = 3 * h + 1) stride = h;
        while (stride > 0) begin
            for (i = stride; i < load_count; i++) begin
                held = load_buf[i];
                j = i;
                while (j >= stride && held < load_buf[j - stride]) begin
                    load_buf[j] = load_buf[j - stride];
                    j -= stride;
                end
                load_buf[j] = held;
            end
            stride = (stride - 1) / 3;
        end
        for (i = 0; i < load_count; i++) begin
            res.value    = load_buf[i];
            res.is_final = (i + 1 == load_count);
            res.dropped  = load_dropped;
            sorted_q.push_back(res);
        end
        load_count   = 0;
        load_dropped = 1'b0;
    endtask

    task automatic queue_item(input logic signed [DATA_W-1:0] v, input logic is_last);
        load_item_t it;
        it.value   = v;
        it.is_last = is_last;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input spread_t spread);
        logic signed [DATA_W-1:0] v;
        case (spread)
            SPREAD_NARROW: begin
                v = int'($urandom_range(0, 8)) - 4;
            end
            SPREAD_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic queue_set(input int unsigned n, input spread_t spread);
        int unsigned k;
        for (k = 0; k < n; k++) queue_item(pick_value(spread), k + 1 == n);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_hold <= 0;
            in_calm <= 0;
        end else begin
            if (s_valid && s_ready) predict_sorted(s_value, s_last);
            if (!s_valid || s_ready) begin
                if (in_hold != 0) begin
                    s_valid <= 1'b0;
                    in_hold <= in_hold - 1;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_valid   <= 1'b1;
                    s_value   <= next_item.value;
                    s_last    <= next_item.is_last;
                    if (in_calm != 0) begin
                        in_calm <= in_calm - 1;
                    end else begin
                        in_hold <= $urandom_range(0, 10);
                        if ($urandom_range(0, 15) == 0) in_calm <= $urandom_range(10, 40);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            out_hold <= 0;
            out_calm <= 0;
        end else if (m_valid && m_ready) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0d final %b overflow %b",
                         $time, m_sorted_value, m_final_res, m_overflow);
                errors++;
            end else begin
                want = sorted_q.pop_front();
                if (m_sorted_value !== want.value) begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.value, m_sorted_value);
                    errors++;
                end
                if (m_final_res !== want.is_final) begin
                    $display("%0t: final_res expected %b actual %b",
                             $time, want.is_final, m_final_res);
                    errors++;
                end
                if (m_overflow !== want.dropped) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.dropped, m_overflow);
                    errors++;
                end
            end
            if (out_calm != 0) begin
                m_ready  <= 1'b1;
                out_calm <= out_calm - 1;
            end else begin
                out_draw = $urandom_range(0, 10);
                m_ready  <= (out_draw == 0);
                out_hold <= out_draw;
                if ($urandom_range(0, 15) == 0) out_calm <= $urandom_range(10, 40);
            end
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            m_ready  <= (out_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        queue_item(32'sh7FFF_FFFF, 1'b1);

        queue_item(32'sh7FFF_FFFF, 1'b0);
        queue_item(32'sh8000_0000, 1'b1);

        queue_item(32'sh7FFF_FFFF, 1'b0);
        queue_item(1000, 1'b0);
        queue_item(1, 1'b0);
        queue_item(0, 1'b0);
        queue_item(0, 1'b0);
        queue_item(-1, 1'b0);
        queue_item(-1000, 1'b0);
        queue_item(32'sh8000_0001, 1'b0);
        queue_item(32'sh8000_0000, 1'b1);

        queue_item(5, 1'b0);
        queue_item(5, 1'b0);
        queue_item(5, 1'b1);

        queue_item(-7, 1'b0);
        queue_item(32'sh5555_5555, 1'b0);
        queue_item(32'shAAAA_AAAA, 1'b0);
        queue_item(3, 1'b1);

        queue_set(CAPACITY + 1, SPREAD_FULL);
        random_items = pending_items.size();
        while (random_items < 120) begin
            if ($urandom_range(0, 7) == 0) set_size = $urandom_range(13, 20);
            else set_size = $urandom_range(1, 12);
            queue_set(set_size, spread_t'($urandom_range(0, 2)));
            random_items += set_size;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (errors == 0) begin
            $display("shell_sort_knuth_gaps_top regression: pass");
        end else begin
            $display("shell_sort_knuth_gaps_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
design/shsk_pkg.sv
design/shsk_ram.sv
design/shell_sort_knuth_gaps_top.sv
tb/shell_sort_knuth_gaps_top_test.sv
